FILE: design/tilt_angle_direction_classifier_defines.svh
// Assertion macros for the tilt classifier top-level design file.
`ifndef TILT_ANGLE_DIRECTION_CLASSIFIER_DEFINES_SVH
`define TILT_ANGLE_DIRECTION_CLASSIFIER_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define TADC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define TADC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tadc_pkg.sv
package tadc_pkg;

    // Field widths.
    localparam int AXIS_W      = 13;
    localparam int ANGLE_OUT_W = 16;
    localparam int DIR_W       = 3;
    localparam int INT_W       = 7;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 2;

    // Square root unit: radicand width and root width.
    localparam int SQ_W      = 42;
    localparam int SQ_ROOT_W = SQ_W / 2;

    // Fixed scaling of the raw samples ahead of the CORDIC.
    localparam int ACCEL_SH = 8;
    localparam int MAG_SH   = 16;

    // CORDIC datapath widths and the arctangent table.
    localparam int CORDIC_W  = 24;
    localparam int ZW        = 28;
    localparam int TAB_LEN   = 24;
    localparam int TAB_IDX_W = 5;
    localparam int TAB_FRAC  = 20;

    // atan(2^-i) in degrees with TAB_FRAC fraction bits.
    localparam logic [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
        28'd47185920, 28'd27855475, 28'd14718068, 28'd7471121,
        28'd3750058,  28'd1876857,  28'd938658,   28'd469357,
        28'd234682,   28'd117342,   28'd58671,    28'd29335,
        28'd14668,    28'd7334,     28'd3667,     28'd1833,
        28'd917,      28'd458,      28'd229,      28'd115,
        28'd57,       28'd29,       28'd14,       28'd7
    };

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_BAND      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAGONAL_MARGIN = 2'd3;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] LEVEL_BAND_RST      = 7'd1;
    localparam logic [CFG_W-1:0] TILT_LIMIT_RST      = 7'd27;
    localparam logic [CFG_W-1:0] UPRIGHT_LIMIT_RST   = 7'd80;
    localparam logic [CFG_W-1:0] DIAGONAL_MARGIN_RST = 7'd2;

    // Direction codes.
    localparam logic [DIR_W-1:0] DIR_NONE     = 3'd0;
    localparam logic [DIR_W-1:0] DIR_FRONT    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_BACK     = 3'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_LEFT     = 3'd4;
    localparam logic [DIR_W-1:0] DIR_DIAG_LR  = 3'd5;
    localparam logic [DIR_W-1:0] DIR_DIAG_RL  = 3'd6;
    localparam logic [DIR_W-1:0] DIR_STABLE   = 3'd7;

    localparam logic [INT_W-1:0] INT_MAX = 7'd127;

    // Threshold registers in whole degrees.
    typedef struct packed {
        logic [CFG_W-1:0] level_band;
        logic [CFG_W-1:0] tilt_limit;
        logic [CFG_W-1:0] upright_limit;
        logic [CFG_W-1:0] diagonal_margin;
    } cfg_set_t;

endpackage

FILE: design/tadc_sqrt.sv
module tadc_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tadc_pkg::SQ_W-1:0]     radicand,
    output logic                          done,
    output logic [tadc_pkg::SQ_ROOT_W-1:0] root
);
    import tadc_pkg::*;

    logic [SQ_W-1:0] rem_reg, rem_next;
    logic [SQ_W-1:0] root_reg, root_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic            done_reg, done_next;
    logic [SQ_W:0]   trial;

    // One result bit per cycle: compare the remainder against root plus the trial bit.
    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = radicand;
            root_next = '0;
            bit_next  = SQ_W'(1) << (SQ_W - 2);
        end
        else if (bit_reg != '0)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next  = rem_reg - trial[SQ_W-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            done_next = bit_reg[0];
        end
    end

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            bit_reg  <= bit_next;
            done_reg <= done_next;
        end
    end

    // Remainder and partial root.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg[SQ_ROOT_W-1:0];

endmodule

FILE: design/tadc_cordic.sv
module tadc_cordic #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 8,
    localparam int ANGLE_W        = ANGLE_FRAC_BITS + 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [tadc_pkg::SQ_ROOT_W-1:0]        x0,
    input  logic signed [tadc_pkg::SQ_ROOT_W-1:0] y0,
    output logic                                  done,
    output logic signed [ANGLE_W-1:0]             angle
);
    import tadc_pkg::*;

    localparam int IW  = $clog2(CORDIC_STEPS);
    localparam int SH  = TAB_FRAC - ANGLE_FRAC_BITS;
    localparam int ZEW = ZW + 1;
    localparam logic signed [ZEW-1:0] HALF = ZEW'(1) << (SH - 1);

    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [ZW-1:0]       z_reg, z_next;
    logic [IW-1:0]              cnt_reg, cnt_next;
    logic                       run_reg, run_next;
    logic                       done_reg, done_next;
    logic                       zero_reg, zero_next;
    logic signed [CORDIC_W-1:0] x_sh, y_sh;
    logic signed [ZW-1:0]       step_angle;
    logic signed [ZEW-1:0]      z_ext;

    // Shifted operands and table entry for the current iteration.
    assign x_sh       = x_reg >>> cnt_reg;
    assign y_sh       = y_reg >>> cnt_reg;
    assign step_angle = $signed(ATAN_TAB[TAB_IDX_W'(cnt_reg)]);

    // Vectoring rotation: drive y toward zero, accumulate the angle in z.
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = CORDIC_W'(x0);
            y_next    = CORDIC_W'(y0);
            z_next    = '0;
            cnt_next  = '0;
            run_next  = 1'b1;
            zero_next = (x0 == '0) && (y0 == '0);
        end
        else if (run_reg)
        begin
            if (!y_reg[CORDIC_W-1])
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + step_angle;
            end
            else
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - step_angle;
            end
            if (cnt_reg == IW'(CORDIC_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Rotation datapath.
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    // Round the accumulated angle to nearest, halves away from zero.
    assign z_ext = ZEW'(z_reg);

    always_comb
    begin
        if (zero_reg)
        begin
            angle = '0;
        end
        else if (!z_reg[ZW-1])
        begin
            angle = ANGLE_W'((z_ext + HALF) >>> SH);
        end
        else
        begin
            angle = ANGLE_W'(-((HALF - z_ext) >>> SH));
        end
    end

    assign done = done_reg;

endmodule

FILE: design/tadc_classify.sv
module tadc_classify #(
    parameter int ANGLE_FRAC_BITS = 8,
    localparam int ANGLE_W        = ANGLE_FRAC_BITS + 8
) (
    input  logic signed [ANGLE_W-1:0]      ax,
    input  logic signed [ANGLE_W-1:0]      ay,
    input  logic signed [ANGLE_W-1:0]      az,
    input  tadc_pkg::cfg_set_t             cfg,
    input  logic [tadc_pkg::DIR_W-1:0]     last_dir,
    output logic [tadc_pkg::DIR_W-1:0]     dir
);
    import tadc_pkg::*;

    localparam int CW = ANGLE_W + 1;

    logic signed [CW-1:0] x, y, z;
    logic signed [CW-1:0] lim_l, lim_t, lim_u, lim_d;
    logic                 x_lvl, y_lvl, no_upright;

    // Angles and thresholds in a common signed width, thresholds scaled to angle units.
    assign x     = CW'(ax);
    assign y     = CW'(ay);
    assign z     = CW'(az);
    assign lim_l = $signed(CW'(cfg.level_band) << ANGLE_FRAC_BITS);
    assign lim_t = $signed(CW'(cfg.tilt_limit) << ANGLE_FRAC_BITS);
    assign lim_u = $signed(CW'(cfg.upright_limit) << ANGLE_FRAC_BITS);
    assign lim_d = $signed(CW'(cfg.diagonal_margin) << ANGLE_FRAC_BITS);

    assign x_lvl      = (x > -lim_l) && (x < lim_l);
    assign y_lvl      = (y > -lim_l) && (y < lim_l);
    assign no_upright = z < lim_u;

    // First matching rule wins; otherwise the previous code is kept.
    always_comb
    begin
        if (x_lvl && (y < lim_l) && (y > -lim_t) && no_upright)
        begin
            dir = DIR_FRONT;
        end
        else if (x_lvl && (y < lim_t) && (y > -lim_l) && no_upright)
        begin
            dir = DIR_BACK;
        end
        else if (y_lvl && (x < lim_l) && (x > -lim_t) && no_upright)
        begin
            dir = DIR_RIGHT;
        end
        else if (y_lvl && (x < lim_t) && (x > -lim_l) && no_upright)
        begin
            dir = DIR_LEFT;
        end
        else if (((x > lim_d) && (y > lim_d)) || ((x < -lim_d) && (y < -lim_d)))
        begin
            dir = DIR_DIAG_LR;
        end
        else if (((x < -lim_d) && (y > lim_d)) || ((x > lim_d) && (y < -lim_d)))
        begin
            dir = DIR_DIAG_RL;
        end
        else if (y_lvl && x_lvl && (z > lim_u))
        begin
            dir = DIR_STABLE;
        end
        else
        begin
            dir = last_dir;
        end
    end

endmodule

FILE: design/tilt_angle_direction_classifier.sv
// Tilt classifier: each accepted item is one accelerometer sample (x, y, z in
// milligravity). For each axis the block squares and sums the other two axes on
// one shared multiplier, takes the square root on a bit-serial unit (one root bit
// per cycle), and runs a vectoring CORDIC (one iteration per cycle) to
// get atan2(axis, magnitude) in 1/2^ANGLE_FRAC_BITS degree. The intensity then
// reuses the multiplier and the square root unit on the x and y angles, and the
// direction is picked by threshold rules from the four configuration registers,
// keeping the previous code when no rule matches. Only one item is in work at a
// time, but a finished result waits in the output register while the next item
// is accepted and worked on.
`include "tilt_angle_direction_classifier_defines.svh"

module tilt_angle_direction_classifier #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [tadc_pkg::AXIS_W-1:0]        accel_x,
    input  logic signed [tadc_pkg::AXIS_W-1:0]        accel_y,
    input  logic signed [tadc_pkg::AXIS_W-1:0]        accel_z,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [tadc_pkg::DIR_W-1:0]                direction,
    output logic [tadc_pkg::INT_W-1:0]                intensity,
    output logic signed [tadc_pkg::ANGLE_OUT_W-1:0]   angle_x,
    output logic signed [tadc_pkg::ANGLE_OUT_W-1:0]   angle_y,
    output logic signed [tadc_pkg::ANGLE_OUT_W-1:0]   angle_z,
    input  logic                                      cfg_write,
    input  logic [tadc_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [tadc_pkg::CFG_W-1:0]                cfg_data
);
    import tadc_pkg::*;

    localparam int ANGLE_W = ANGLE_FRAC_BITS + 8;
    localparam int MUL_W   = ANGLE_FRAC_BITS + 9;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = PROD_W + 1;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_SQ_B       = 4'd1;
    localparam logic [3:0] ST_SQ_C       = 4'd2;
    localparam logic [3:0] ST_ROOT_GO    = 4'd3;
    localparam logic [3:0] ST_ROOT_WAIT  = 4'd4;
    localparam logic [3:0] ST_ROT_GO     = 4'd5;
    localparam logic [3:0] ST_ROT_WAIT   = 4'd6;
    localparam logic [3:0] ST_INT_PREP   = 4'd7;
    localparam logic [3:0] ST_SQ_P       = 4'd8;
    localparam logic [3:0] ST_SQ_M       = 4'd9;
    localparam logic [3:0] ST_IROOT_GO   = 4'd10;
    localparam logic [3:0] ST_IROOT_WAIT = 4'd11;
    localparam logic [3:0] ST_FIN        = 4'd12;

    // Axis being resolved.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    logic [3:0]                 state_reg, state_next;
    logic [1:0]                 axis_reg, axis_next;
    logic [DIR_W-1:0]           last_dir_reg;
    logic                       out_valid_reg;
    cfg_set_t                   cfg_reg;

    logic signed [AXIS_W-1:0]   x_reg, y_reg, z_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [SQ_ROOT_W-1:0]       mag_reg;
    logic signed [ANGLE_W-1:0]  ang_reg [3];
    logic signed [MUL_W-1:0]    p_reg, m_reg;
    logic [INT_W-1:0]           int_reg;

    logic [DIR_W-1:0]           dir_out_reg;
    logic [INT_W-1:0]           int_out_reg;
    logic signed [ANGLE_W-1:0]  ax_out_reg, ay_out_reg, az_out_reg;

    logic signed [AXIS_W-1:0]   op_a, op_b, op_c;
    logic signed [MUL_W-1:0]    mul_op;
    logic signed [PROD_W-1:0]   product;
    logic [ACC_W-1:0]           prod_ext;

    logic                       sqrt_start, sqrt_done;
    logic [SQ_W-1:0]            sqrt_in;
    logic [SQ_ROOT_W-1:0]       sqrt_root;
    logic                       cordic_start, cordic_done;
    logic signed [SQ_ROOT_W-1:0] cordic_y0;
    logic signed [ANGLE_W-1:0]  cordic_angle;
    logic [DIR_W-1:0]           dir_new;

    logic                       accept, out_load;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_band      <= LEVEL_BAND_RST;
            cfg_reg.tilt_limit      <= TILT_LIMIT_RST;
            cfg_reg.upright_limit   <= UPRIGHT_LIMIT_RST;
            cfg_reg.diagonal_margin <= DIAGONAL_MARGIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LEVEL_BAND:      cfg_reg.level_band      <= cfg_data;
                CFG_TILT_LIMIT:      cfg_reg.tilt_limit      <= cfg_data;
                CFG_UPRIGHT_LIMIT:   cfg_reg.upright_limit   <= cfg_data;
                CFG_DIAGONAL_MARGIN: cfg_reg.diagonal_margin <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Route the sample so that the axis under work is op_a and the others are op_b, op_c.
    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                op_a = x_reg;
                op_b = y_reg;
                op_c = z_reg;
            end
            AXIS_Y:
            begin
                op_a = y_reg;
                op_b = x_reg;
                op_c = z_reg;
            end
            default:
            begin
                op_a = z_reg;
                op_b = x_reg;
                op_c = y_reg;
            end
        endcase
    end

    // Shared squaring multiplier.
    always_comb
    begin
        case (state_reg)
            ST_SQ_B: mul_op = MUL_W'(op_b);
            ST_SQ_C: mul_op = MUL_W'(op_c);
            ST_SQ_P: mul_op = p_reg;
            default: mul_op = m_reg;
        endcase
    end

    assign product  = mul_op * mul_op;
    assign prod_ext = ACC_W'($unsigned(product));

    // Square root input: magnitude radicand carries 16 fraction bits; the intensity
    // radicand drops the angle fraction bits of both factors up front.
    assign sqrt_start = (state_reg == ST_ROOT_GO) || (state_reg == ST_IROOT_GO);
    assign sqrt_in    = (state_reg == ST_ROOT_GO) ?
                        {acc_reg[SQ_W-MAG_SH-1:0], MAG_SH'(0)} :
                        SQ_W'(acc_reg >> (2 * ANGLE_FRAC_BITS));

    tadc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // CORDIC takes the axis scaled by 256 against the magnitude of the other two.
    assign cordic_start = (state_reg == ST_ROT_GO);
    assign cordic_y0    = $signed({op_a, ACCEL_SH'(0)});

    tadc_cordic #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x0    (mag_reg),
        .y0    (cordic_y0),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    tadc_classify #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_classify (
        .ax       (ang_reg[0]),
        .ay       (ang_reg[1]),
        .az       (ang_reg[2]),
        .cfg      (cfg_reg),
        .last_dir (last_dir_reg),
        .dir      (dir_new)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SQ_B;
                    axis_next  = AXIS_X;
                end
            end
            ST_SQ_B:      state_next = ST_SQ_C;
            ST_SQ_C:      state_next = ST_ROOT_GO;
            ST_ROOT_GO:   state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_ROT_GO;
                end
            end
            ST_ROT_GO:    state_next = ST_ROT_WAIT;
            ST_ROT_WAIT:
            begin
                if (cordic_done)
                begin
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = ST_INT_PREP;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_SQ_B;
                    end
                end
            end
            ST_INT_PREP:  state_next = ST_SQ_P;
            ST_SQ_P:      state_next = ST_SQ_M;
            ST_SQ_M:      state_next = ST_IROOT_GO;
            ST_IROOT_GO:  state_next = ST_IROOT_WAIT;
            ST_IROOT_WAIT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_X;
            last_dir_reg  <= DIR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            if (out_load)
            begin
                last_dir_reg  <= dir_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working datapath.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= accel_x;
            y_reg <= accel_y;
            z_reg <= accel_z;
        end
        if ((state_reg == ST_SQ_B) || (state_reg == ST_SQ_P))
        begin
            acc_reg <= prod_ext;
        end
        else if ((state_reg == ST_SQ_C) || (state_reg == ST_SQ_M))
        begin
            acc_reg <= acc_reg + prod_ext;
        end
        if ((state_reg == ST_ROOT_WAIT) && sqrt_done)
        begin
            mag_reg <= sqrt_root;
        end
        if ((state_reg == ST_ROT_WAIT) && cordic_done)
        begin
            ang_reg[axis_reg] <= cordic_angle;
        end
        if (state_reg == ST_INT_PREP)
        begin
            p_reg <= MUL_W'(ang_reg[0]) + MUL_W'(ang_reg[1]);
            m_reg <= MUL_W'(ang_reg[0]) - MUL_W'(ang_reg[1]);
        end
        if ((state_reg == ST_IROOT_WAIT) && sqrt_done)
        begin
            int_reg <= (sqrt_root > SQ_ROOT_W'(INT_MAX)) ? INT_MAX : sqrt_root[INT_W-1:0];
        end
    end

    // Output register holds the finished item until it is taken.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            dir_out_reg <= dir_new;
            int_out_reg <= int_reg;
            ax_out_reg  <= ang_reg[0];
            ay_out_reg  <= ang_reg[1];
            az_out_reg  <= ang_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign direction = dir_out_reg;
    assign intensity = int_out_reg;
    assign angle_x   = ANGLE_OUT_W'(ax_out_reg);
    assign angle_y   = ANGLE_OUT_W'(ay_out_reg);
    assign angle_z   = ANGLE_OUT_W'(az_out_reg);

    // An accepted item starts with the first squaring step.
    `TADC_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_reg == ST_SQ_B, "accepted item did not start")
    // The square root unit finishes only while the sequencer waits for it.
    `TADC_ASSERT_NOW(a_sqrt_done_waited, clk, rst_n, sqrt_done, (state_reg == ST_ROOT_WAIT) || (state_reg == ST_IROOT_WAIT), "square root finished outside a wait state")
    // The CORDIC unit finishes only while the sequencer waits for it.
    `TADC_ASSERT_NOW(a_cordic_done_waited, clk, rst_n, cordic_done, state_reg == ST_ROT_WAIT, "CORDIC finished outside its wait state")
    // The kept direction changes only when a result is loaded.
    `TADC_ASSERT_NEXT(a_dir_held, clk, rst_n, !out_load, $stable(last_dir_reg), "direction changed without a result")

endmodule

FILE: verif/tb_tilt_angle_direction_classifier.sv
`timescale 1ns / 100ps

module tb_tilt_angle_direction_classifier;

    import tadc_pkg::*;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int ROUND_SH        = TAB_FRAC - ANGLE_FRAC_BITS;
    localparam int LATENCY         = 3 * (CORDIC_STEPS + 27) + 27;
    localparam int HOLD_CYCLES     = 600;
    localparam int STALL_LIMIT     = 4000;
    localparam int PRINT_CAP       = 40;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [DIR_W-1:0]       direction;
        logic [INT_W-1:0]       intensity;
        logic [ANGLE_OUT_W-1:0] angle_x;
        logic [ANGLE_OUT_W-1:0] angle_y;
        logic [ANGLE_OUT_W-1:0] angle_z;
    } tilt_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [AXIS_W-1:0]      accel_x;
    logic signed [AXIS_W-1:0]      accel_y;
    logic signed [AXIS_W-1:0]      accel_z;
    logic                          out_valid;
    logic                          out_ready;
    logic [DIR_W-1:0]              direction;
    logic [INT_W-1:0]              intensity;
    logic signed [ANGLE_OUT_W-1:0] angle_x;
    logic signed [ANGLE_OUT_W-1:0] angle_y;
    logic signed [ANGLE_OUT_W-1:0] angle_z;
    logic                          cfg_write;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_W-1:0]              cfg_data;

    // Predictor state: threshold registers and the sticky direction code.
    cfg_set_t         thresholds;
    logic [DIR_W-1:0] last_dir;

    tilt_result_t pending_tilts[$];
    tilt_result_t oldest;

    int error_count;
    int samples_in;
    int results_checked;
    int settings_used;
    int idle_cycles;
    bit send_calm;
    bit recv_calm;
    int hold_asked;
    int hold_served;
    int stall_left;

    tilt_angle_direction_classifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .direction (direction),
        .intensity (intensity),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .angle_z   (angle_z),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Integer square root, rounded down.
    function automatic u64_t int_sqrt(u64_t n);
        u64_t root;
        u64_t bitv;
        root = 0;
        bitv = u64_t'(1) << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Vectoring CORDIC for atan2(a, sqrt(b^2 + c^2)) in output angle units.
    function automatic longint axis_tilt(longint a, longint b, longint c);
        longint yy;
        longint xx;
        longint zz;
        longint nx;
        longint half;
        yy   = a * 256;
        xx   = longint'(int_sqrt(u64_t'(b * b + c * c) << 16));
        zz   = 0;
        half = longint'(1) << (ROUND_SH - 1);
        if (yy == 0 && xx == 0)
            return 0;
        for (int i = 0; i < CORDIC_STEPS && i < TAB_LEN; i++)
        begin
            if (yy >= 0)
            begin
                nx = xx + (yy >>> i);
                yy = yy - (xx >>> i);
                zz = zz + longint'(ATAN_TAB[i]);
            end
            else
            begin
                nx = xx - (yy >>> i);
                yy = yy + (xx >>> i);
                zz = zz - longint'(ATAN_TAB[i]);
            end
            xx = nx;
        end
        // Round to nearest, halves away from zero.
        if (zz >= 0)
            return (zz + half) >>> ROUND_SH;
        return -((-zz + half) >>> ROUND_SH);
    endfunction

    // Expected result for one sample; updates the sticky direction code.
    function automatic tilt_result_t predict_tilt(logic signed [AXIS_W-1:0] sx,
                                                  logic signed [AXIS_W-1:0] sy,
                                                  logic signed [AXIS_W-1:0] sz);
        longint       x, y, z;
        longint       ax, ay, az;
        longint       lb, tl, ul, dm;
        longint       s;
        bit           xl, yl;
        u64_t         mag;
        tilt_result_t r;
        x  = sx;
        y  = sy;
        z  = sz;
        ax = axis_tilt(x, y, z);
        ay = axis_tilt(y, x, z);
        az = axis_tilt(z, x, y);
        lb = longint'(thresholds.level_band) << ANGLE_FRAC_BITS;
        tl = longint'(thresholds.tilt_limit) << ANGLE_FRAC_BITS;
        ul = longint'(thresholds.upright_limit) << ANGLE_FRAC_BITS;
        dm = longint'(thresholds.diagonal_margin) << ANGLE_FRAC_BITS;
        xl = (ax > -lb) && (ax < lb);
        yl = (ay > -lb) && (ay < lb);

        // First matching rule wins; no match keeps the previous code.
        if (xl && ay < lb && ay > -tl && az < ul)
            last_dir = DIR_FRONT;
        else if (xl && ay < tl && ay > -lb && az < ul)
            last_dir = DIR_BACK;
        else if (yl && ax < lb && ax > -tl && az < ul)
            last_dir = DIR_RIGHT;
        else if (yl && ax < tl && ax > -lb && az < ul)
            last_dir = DIR_LEFT;
        else if ((ax > dm && ay > dm) || (ax < -dm && ay < -dm))
            last_dir = DIR_DIAG_LR;
        else if ((ax < -dm && ay > dm) || (ax > dm && ay < -dm))
            last_dir = DIR_DIAG_RL;
        else if (yl && xl && az > ul)
            last_dir = DIR_STABLE;

        s   = (ax + ay) * (ax + ay) + (ax - ay) * (ax - ay);
        mag = int_sqrt(u64_t'(s)) >> ANGLE_FRAC_BITS;

        r.direction = last_dir;
        r.intensity = (mag > u64_t'(INT_MAX)) ? INT_MAX : mag[INT_W-1:0];
        r.angle_x   = ax[ANGLE_OUT_W-1:0];
        r.angle_y   = ay[ANGLE_OUT_W-1:0];
        r.angle_z   = az[ANGLE_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t MISMATCH %s", $time, msg);
    endtask

    // Scoreboard: check results against the oldest prediction, then
    // record a prediction for each accepted sample.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_tilts.size() == 0)
            begin
                report_mismatch($sformatf("result with no sample pending (direction %0d)",
                                          direction));
            end
            else
            begin
                oldest = pending_tilts.pop_front();
                results_checked++;
                if (direction !== oldest.direction)
                    report_mismatch($sformatf("direction: got %0d, want %0d",
                                              direction, oldest.direction));
                if (intensity !== oldest.intensity)
                    report_mismatch($sformatf("intensity: got %0d, want %0d",
                                              intensity, oldest.intensity));
                if (angle_x !== oldest.angle_x)
                    report_mismatch($sformatf("angle_x: got %0d, want %0d",
                                              angle_x, $signed(oldest.angle_x)));
                if (angle_y !== oldest.angle_y)
                    report_mismatch($sformatf("angle_y: got %0d, want %0d",
                                              angle_y, $signed(oldest.angle_y)));
                if (angle_z !== oldest.angle_z)
                    report_mismatch($sformatf("angle_z: got %0d, want %0d",
                                              angle_z, $signed(oldest.angle_z)));
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            pending_tilts.push_back(predict_tilt(accel_x, accel_y, accel_z));
            samples_in++;
        end
    end

    // Result receiver: random stalls, calm stretches and a long hold-off on request.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served <= hold_asked;
            stall_left  <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= recv_calm || ($urandom_range(0, 99) >= 38);
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offer one sample and wait until it is accepted; valid stays high afterwards.
    task automatic send_sample(input int x, input int y, input int z);
        int gap;
        gap = 0;
        if (!send_calm && $urandom_range(0, 99) < 38)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 220)
                                                : $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x  <= x[AXIS_W-1:0];
        accel_y  <= y[AXIS_W-1:0];
        accel_z  <= z[AXIS_W-1:0];
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    // Stop offering and wait until every predicted result has arrived. The first
    // edge lets the scoreboard record the sample accepted at the current edge.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_tilts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_LEVEL_BAND:      thresholds.level_band      = value;
            CFG_TILT_LIMIT:      thresholds.tilt_limit      = value;
            CFG_UPRIGHT_LIMIT:   thresholds.upright_limit   = value;
            CFG_DIAGONAL_MARGIN: thresholds.diagonal_margin = value;
            default: ;
        endcase
    endtask

    // Write all four thresholds; only called while the block is idle.
    task automatic apply_settings(input logic [CFG_W-1:0] lb, input logic [CFG_W-1:0] tl,
                                  input logic [CFG_W-1:0] ul, input logic [CFG_W-1:0] dm);
        write_register(CFG_LEVEL_BAND, lb);
        write_register(CFG_TILT_LIMIT, tl);
        write_register(CFG_UPRIGHT_LIMIT, ul);
        write_register(CFG_DIAGONAL_MARGIN, dm);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Random samples, weighted toward small tilts where the rules are decided.
    task automatic send_random(input int count);
        int x, y, z, pick, lone;
        int corners[5];
        corners = '{-4096, -1, 0, 1, 4095};
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                x = $urandom_range(0, 8191) - 4096;
                y = $urandom_range(0, 8191) - 4096;
                z = $urandom_range(0, 8191) - 4096;
            end
            else if (pick < 60)
            begin
                x = $urandom_range(0, 800) - 400;
                y = $urandom_range(0, 800) - 400;
                z = $urandom_range(200, 4095);
                if ($urandom_range(0, 3) == 0)
                    z = -z;
            end
            else if (pick < 75)
            begin
                x = $urandom_range(0, 6) - 3;
                y = $urandom_range(0, 6) - 3;
                z = $urandom_range(0, 6) - 3;
            end
            else if (pick < 90)
            begin
                x = corners[$urandom_range(0, 4)];
                y = corners[$urandom_range(0, 4)];
                z = corners[$urandom_range(0, 4)];
            end
            else
            begin
                lone = $urandom_range(0, 8191) - 4096;
                x = 0;
                y = 0;
                z = 0;
                case ($urandom_range(0, 2))
                    0:       x = lone;
                    1:       y = lone;
                    default: z = lone;
                endcase
            end
            send_sample(x, y, z);
        end
    endtask

    // Axis extremes, zero input, intensity saturation and one sample per direction.
    task automatic test_directed_cases();
        send_sample(0, 0, 0);
        send_sample(4095, 4095, 4095);
        send_sample(-4096, -4096, -4096);
        send_sample(4095, 0, 0);
        send_sample(-4096, 0, 0);
        send_sample(0, 4095, 0);
        send_sample(0, -4096, 0);
        send_sample(0, 0, 4095);
        send_sample(0, 0, -4096);
        send_sample(4095, -4096, 0);
        send_sample(-4096, 4095, 4095);
        send_sample(1, -1, 1);
        send_sample(0, -200, 1000);
        send_sample(0, 200, 1000);
        send_sample(-200, 0, 1000);
        send_sample(200, 0, 1000);
        send_sample(500, 500, 500);
        send_sample(-500, -500, 500);
        send_sample(-500, 500, 500);
        send_sample(500, -500, 500);
        send_sample(0, 0, 1000);
        // No rule matches here, so the stable code must be kept.
        send_sample(1000, 0, 0);
        send_sample(0, 0, 0);
        settle();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_output_backpressure();
        send_calm  = 1'b1;
        hold_asked <= hold_asked + 1;
        send_random(10);
        settle();
        send_calm = 1'b0;
        send_random(4);
        settle();
    endtask

    // Back-to-back samples with both sides always ready.
    task automatic test_full_rate();
        send_calm = 1'b1;
        recv_calm = 1'b1;
        send_random(330);
        settle();
        send_calm = 1'b0;
        recv_calm = 1'b0;
    endtask

    // Threshold settings: zero, out of range, top of range, a mixed setting, random, then reset values.
    task automatic test_threshold_sweep();
        apply_settings(7'd0, 7'd0, 7'd0, 7'd0);
        send_random(135);
        settle();
        apply_settings(7'd127, 7'd127, 7'd127, 7'd127);
        send_random(135);
        settle();
        apply_settings(7'd90, 7'd90, 7'd90, 7'd90);
        send_random(135);
        settle();
        apply_settings(7'd5, 7'd45, 7'd60, 7'd10);
        send_random(135);
        settle();
        repeat (3)
        begin
            apply_settings(CFG_W'($urandom_range(0, 127)), CFG_W'($urandom_range(0, 90)),
                           CFG_W'($urandom_range(0, 90)), CFG_W'($urandom_range(0, 127)));
            send_random(135);
            settle();
        end
        apply_settings(LEVEL_BAND_RST, TILT_LIMIT_RST, UPRIGHT_LIMIT_RST,
                       DIAGONAL_MARGIN_RST);
        send_random(135);
        settle();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        accel_x     = '0;
        accel_y     = '0;
        accel_z     = '0;
        out_ready   = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = CFG_LEVEL_BAND;
        cfg_data    = '0;
        error_count = 0;
        samples_in  = 0;
        results_checked = 0;
        settings_used   = 0;
        idle_cycles = 0;
        send_calm   = 1'b0;
        recv_calm   = 1'b0;
        hold_asked  = 0;
        hold_served = 0;
        stall_left  = 0;
        thresholds.level_band      = LEVEL_BAND_RST;
        thresholds.tilt_limit      = TILT_LIMIT_RST;
        thresholds.upright_limit   = UPRIGHT_LIMIT_RST;
        thresholds.diagonal_margin = DIAGONAL_MARGIN_RST;
        last_dir = DIR_NONE;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_output_backpressure();
        test_full_rate();
        test_threshold_sweep();

        // Let any stray result show up before the final check.
        settle();
        repeat (LATENCY + 20) @(posedge clk);
        if (pending_tilts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_tilts.size()));

        $display("Checked %0d results from %0d samples over %0d threshold settings,",
                 results_checked, samples_in, settings_used);
        $display("with a long output hold-off and a full-rate stretch; %0d mismatches.",
                 error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
